@@ sv/grid_raycast_column_defines.svh @@
// Assertion macros shared by the grid column ray caster checks
`ifndef GRID_RAYCAST_COLUMN_DEFINES_SVH
`define GRID_RAYCAST_COLUMN_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define GRC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("grid_raycast_column: check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define GRC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("grid_raycast_column: check failed");

`endif

@@ sv/grc_pkg.sv @@
`timescale 1ns / 1ps
// Package: constants, command and status types and the sine table of the ray caster
package grc_pkg;

   localparam int MAP_SIDE           = 16;
   localparam int MAP_BITS           = $clog2(MAP_SIDE);
   localparam int MAP_CELLS          = MAP_SIDE * MAP_SIDE;
   localparam int ADDR_BITS          = $clog2(MAP_CELLS);
   localparam int SCREEN_COLUMNS     = 512;
   localparam int COL_BITS           = $clog2(SCREEN_COLUMNS);
   localparam int TRIG_TABLE_ENTRIES = 1024;
   localparam int TRIG_BITS          = $clog2(TRIG_TABLE_ENTRIES);
   localparam int QUARTER_ENTRIES    = TRIG_TABLE_ENTRIES / 4;
   localparam int QUARTER_BITS       = TRIG_BITS - 2;
   localparam int ANGLE_BITS         = 16;
   localparam int ANGLE_STEP         = 65536 / TRIG_TABLE_ENTRIES;

   localparam int POS_BITS      = 16;
   localparam int FOV_BITS      = 15;
   localparam int STEP_BITS     = 12;
   localparam int DIST_BITS     = 17;
   localparam int T_BITS        = DIST_BITS + 1;
   localparam int SH_BITS       = 10;
   localparam int CODE_BITS     = 4;
   localparam int TRIG_W        = 16;
   localparam int TRIG_FRAC     = 14;
   localparam int POS_FRAC      = 12;
   localparam int CELL_SHIFT    = TRIG_FRAC + POS_FRAC;
   localparam int ACC_BITS      = 36;
   localparam int MUL_A_BITS    = T_BITS;
   localparam int PROD_BITS     = MUL_A_BITS + TRIG_W;
   localparam int DIVIDEND_BITS = SH_BITS + POS_FRAC;
   localparam int DIVISOR_BITS  = T_BITS;
   localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS + 1);

   localparam logic [CODE_BITS-1:0]  CELL_EMPTY   = 4'd10;
   localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = 16'd16384;

   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = DIST_BITS;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PLAYER_X      = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PLAYER_Y      = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PLAYER_ANGLE  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIELD_OF_VIEW = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MARCH_STEP    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_DISTANCE  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_HEIGHT = 3'd6;

   localparam int OP_BITS = 4;
   localparam logic [OP_BITS-1:0] OP_NONE     = 4'd0;
   localparam logic [OP_BITS-1:0] OP_LOAD     = 4'd1;
   localparam logic [OP_BITS-1:0] OP_CAST     = 4'd2;
   localparam logic [OP_BITS-1:0] OP_LUT_C    = 4'd3;
   localparam logic [OP_BITS-1:0] OP_LUT_S    = 4'd4;
   localparam logic [OP_BITS-1:0] OP_LUT_D    = 4'd5;
   localparam logic [OP_BITS-1:0] OP_MUL_X    = 4'd6;
   localparam logic [OP_BITS-1:0] OP_MUL_Y    = 4'd7;
   localparam logic [OP_BITS-1:0] OP_MARCH    = 4'd8;
   localparam logic [OP_BITS-1:0] OP_PERP     = 4'd9;
   localparam logic [OP_BITS-1:0] OP_DIV_INIT = 4'd10;
   localparam logic [OP_BITS-1:0] OP_DIV      = 4'd11;
   localparam logic [OP_BITS-1:0] OP_FINISH   = 4'd12;

   localparam logic [63:0] SERIES_DEN_1 = 64'd6;
   localparam logic [63:0] SERIES_DEN_2 = 64'd20;
   localparam logic [63:0] SERIES_DEN_3 = 64'd42;
   localparam logic [63:0] SERIES_DEN_4 = 64'd72;
   localparam logic [63:0] SERIES_DEN_5 = 64'd110;
   localparam logic [63:0] SERIES_DEN_6 = 64'd156;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic col_ok;
      logic march_hit;
      logic march_miss;
      logic perp_ok;
      logic div_done;
      logic rsp_busy;
   } status_type;

   typedef logic [TRIG_W-1:0] qsine_tab_type [QUARTER_ENTRIES+1];

   function automatic logic [TRIG_W-1:0] quarter_sine(input logic [31:0] q);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x    = (64'(q) * 64'd6746518852) >> 16;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / SERIES_DEN_1;
      sum  = (sum >= term) ? sum - term : 64'd0;
      term = ((term * x2) >> 30) / SERIES_DEN_2;
      sum  = sum + term;
      term = ((term * x2) >> 30) / SERIES_DEN_3;
      sum  = (sum >= term) ? sum - term : 64'd0;
      term = ((term * x2) >> 30) / SERIES_DEN_4;
      sum  = sum + term;
      term = ((term * x2) >> 30) / SERIES_DEN_5;
      sum  = (sum >= term) ? sum - term : 64'd0;
      term = ((term * x2) >> 30) / SERIES_DEN_6;
      sum  = sum + term;
      sum = (sum + 64'd32768) >> 16;
      if (sum > 64'd16384) begin
         sum = 64'd16384;
      end
      return sum[TRIG_W-1:0];
   endfunction

   function automatic qsine_tab_type build_qsine();
      qsine_tab_type tab;
      for (int m = 0; m <= QUARTER_ENTRIES; m++) begin
         tab[m] = quarter_sine(32'(m * ANGLE_STEP));
      end
      return tab;
   endfunction

   localparam qsine_tab_type QSINE = build_qsine();

   function automatic logic signed [TRIG_W-1:0] sine_lookup(
      input logic [ANGLE_BITS-1:0] angle
   );
      logic [TRIG_BITS-1:0]  idx;
      logic [QUARTER_BITS:0] m;
      logic [TRIG_W-1:0]     v;
      idx = angle[ANGLE_BITS-1 -: TRIG_BITS];
      if (idx[TRIG_BITS-2]) begin
         m = (QUARTER_BITS + 1)'(QUARTER_ENTRIES) - {1'b0, idx[QUARTER_BITS-1:0]};
      end else begin
         m = {1'b0, idx[QUARTER_BITS-1:0]};
      end
      v = QSINE[m];
      return idx[TRIG_BITS-1] ? $signed(-v) : $signed(v);
   endfunction

endpackage

@@ sv/grid_raycast_column.sv @@
`timescale 1ns / 1ps
// Top level of the grid column ray caster
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    operation, cell_index, cell_code, column
//   rsp      out        rsp_valid/stall    column_out, hit, wall_code, distance, top, height
//   csr      in         csr_valid/ready    csr_index, csr_data
//
// A map load writes one cell. A cast runs setup (accept, three trig lookups, two multiplies),
// the march loop (one map RAM read per step), the perpendicular multiply, the height divider
// (both skipped on a miss) and finally the result register.
// Reset is synchronous; the map reads empty after reset through per-cell valid bits.
// A result waits in the output register while the next item is taken; rsp_stall
// holds a finished cast only when a second one completes behind it.
module grid_raycast_column (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [7:0]                          req_cell_index,
   input  logic [grc_pkg::CODE_BITS-1:0]       req_cell_code,
   input  logic [8:0]                          req_column,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [8:0]                          rsp_column_out,
   output logic                                rsp_hit,
   output logic [grc_pkg::CODE_BITS-1:0]       rsp_wall_code,
   output logic [grc_pkg::DIST_BITS-1:0]       rsp_distance,
   output logic [grc_pkg::SH_BITS-1:0]         rsp_column_top,
   output logic [grc_pkg::SH_BITS-1:0]         rsp_column_height,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [grc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [grc_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   grc_pkg::cmd_type    cmd;
   grc_pkg::status_type status;

   assign csr_ready = 1'b1;

   grc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .status        (status),
      .req_stall     (req_stall),
      .cmd           (cmd)
   );

   grc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_cell_index    (req_cell_index),
      .req_cell_code     (req_cell_code),
      .req_column        (req_column),
      .csr_valid         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_column_out    (rsp_column_out),
      .rsp_hit           (rsp_hit),
      .rsp_wall_code     (rsp_wall_code),
      .rsp_distance      (rsp_distance),
      .rsp_column_top    (rsp_column_top),
      .rsp_column_height (rsp_column_height)
   );

endmodule

@@ sv/grc_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data
module grc_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/grc_divider.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle while step_en is high, for the wall slice height
module grc_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               step_en,
   input  logic [grc_pkg::DIVIDEND_BITS-1:0]  dividend,
   input  logic [grc_pkg::DIVISOR_BITS-1:0]   divisor,
   output logic [grc_pkg::DIVIDEND_BITS-1:0]  quotient,
   output logic                               done
);

   logic [grc_pkg::DIV_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [grc_pkg::DIVISOR_BITS-1:0]   rem_ff, rem_in;
   logic [grc_pkg::DIVIDEND_BITS-1:0]  quo_ff, quo_in;
   logic [grc_pkg::DIVISOR_BITS-1:0]   den_ff, den_in;
   logic [grc_pkg::DIVISOR_BITS:0]     rem_sh;
   logic [grc_pkg::DIVISOR_BITS:0]     rem_sub;

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_sh  = {rem_ff, quo_ff[grc_pkg::DIVIDEND_BITS-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      if (start) begin
         cnt_in = grc_pkg::DIV_CNT_BITS'(grc_pkg::DIVIDEND_BITS);
         rem_in = '0;
         quo_in = dividend;
         den_in = divisor;
      end else if (step_en && (cnt_ff != '0)) begin
         cnt_in = cnt_ff - 1'b1;
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sub[grc_pkg::DIVISOR_BITS-1:0];
            quo_in = {quo_ff[grc_pkg::DIVIDEND_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[grc_pkg::DIVISOR_BITS-1:0];
            quo_in = {quo_ff[grc_pkg::DIVIDEND_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign done     = (cnt_ff == '0);

endmodule

@@ sv/grc_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: sequences loads and casts through setup, march, height division and output
module grc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_operation,
   input  grc_pkg::status_type  status,
   output logic                 req_stall,
   output grc_pkg::cmd_type     cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_LUT_C    = 4'd1;
   localparam logic [3:0] S_LUT_S    = 4'd2;
   localparam logic [3:0] S_LUT_D    = 4'd3;
   localparam logic [3:0] S_MUL_X    = 4'd4;
   localparam logic [3:0] S_MUL_Y    = 4'd5;
   localparam logic [3:0] S_MARCH    = 4'd6;
   localparam logic [3:0] S_PERP     = 4'd7;
   localparam logic [3:0] S_DIV_INIT = 4'd8;
   localparam logic [3:0] S_DIV      = 4'd9;
   localparam logic [3:0] S_DONE     = 4'd10;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = grc_pkg::OP_NONE;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (!req_operation) begin
                  cmd.op = grc_pkg::OP_LOAD;
               end else if (status.col_ok) begin
                  cmd.op   = grc_pkg::OP_CAST;
                  state_in = S_LUT_C;
               end
            end
         end
         S_LUT_C: begin
            cmd.op   = grc_pkg::OP_LUT_C;
            state_in = S_LUT_S;
         end
         S_LUT_S: begin
            cmd.op   = grc_pkg::OP_LUT_S;
            state_in = S_LUT_D;
         end
         S_LUT_D: begin
            cmd.op   = grc_pkg::OP_LUT_D;
            state_in = S_MUL_X;
         end
         S_MUL_X: begin
            cmd.op   = grc_pkg::OP_MUL_X;
            state_in = S_MUL_Y;
         end
         S_MUL_Y: begin
            cmd.op   = grc_pkg::OP_MUL_Y;
            state_in = S_MARCH;
         end
         S_MARCH: begin
            cmd.op = grc_pkg::OP_MARCH;
            if (status.march_hit) begin
               state_in = S_PERP;
            end else if (status.march_miss) begin
               state_in = S_DONE;
            end
         end
         S_PERP: begin
            cmd.op   = grc_pkg::OP_PERP;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.op   = grc_pkg::OP_DIV_INIT;
            state_in = status.perp_ok ? S_DIV : S_DONE;
         end
         S_DIV: begin
            cmd.op = grc_pkg::OP_DIV;
            if (status.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!status.rsp_busy) begin
               cmd.op   = grc_pkg::OP_FINISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/grc_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: settings, map store, ray setup, march loop, height division and result register
module grc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  grc_pkg::cmd_type                    cmd,
   output grc_pkg::status_type                 status,
   input  logic [7:0]                          req_cell_index,
   input  logic [grc_pkg::CODE_BITS-1:0]       req_cell_code,
   input  logic [8:0]                          req_column,
   input  logic                                csr_valid,
   input  logic [grc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [grc_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [8:0]                          rsp_column_out,
   output logic                                rsp_hit,
   output logic [grc_pkg::CODE_BITS-1:0]       rsp_wall_code,
   output logic [grc_pkg::DIST_BITS-1:0]       rsp_distance,
   output logic [grc_pkg::SH_BITS-1:0]         rsp_column_top,
   output logic [grc_pkg::SH_BITS-1:0]         rsp_column_height
);

   // settings
   logic [grc_pkg::POS_BITS-1:0]   player_x_ff, player_y_ff;
   logic [grc_pkg::ANGLE_BITS-1:0] player_angle_ff;
   logic [grc_pkg::FOV_BITS-1:0]   fov_ff;
   logic [grc_pkg::STEP_BITS-1:0]  march_step_ff;
   logic [grc_pkg::DIST_BITS-1:0]  max_distance_ff;
   logic [grc_pkg::SH_BITS-1:0]    screen_height_ff;

   // map store
   logic [grc_pkg::MAP_CELLS-1:0]  cell_valid_ff;
   logic                           map_we;
   logic [grc_pkg::CODE_BITS-1:0]  map_wdata;
   logic [grc_pkg::ADDR_BITS-1:0]  map_raddr;
   logic [grc_pkg::CODE_BITS-1:0]  map_q;
   logic                           vld_q_ff;
   logic [grc_pkg::CODE_BITS-1:0]  code_eff;

   // ray setup
   logic [8:0]                         column_ff;
   logic [grc_pkg::ANGLE_BITS-1:0]     ray_ff;
   logic [grc_pkg::FOV_BITS+8:0]       offset_prod;
   logic [grc_pkg::ANGLE_BITS-1:0]     ray_in;
   logic [grc_pkg::ANGLE_BITS-1:0]     lut_angle;
   logic signed [grc_pkg::TRIG_W-1:0]  lut_val;
   logic signed [grc_pkg::TRIG_W-1:0]  cos_ff, sin_ff, cd_ff;
   logic [grc_pkg::STEP_BITS-1:0]      step_eff;

   // shared multiplier
   logic signed [grc_pkg::MUL_A_BITS-1:0] mul_a;
   logic signed [grc_pkg::TRIG_W-1:0]     mul_b;
   logic signed [grc_pkg::PROD_BITS-1:0]  mul_p;
   logic signed [grc_pkg::PROD_BITS-1:0]  dx_ff, dy_ff, perp_ff;

   // march
   logic [grc_pkg::T_BITS-1:0]           t_ff;
   logic signed [grc_pkg::ACC_BITS-1:0]  acc_x_ff, acc_y_ff;
   logic                                 b_valid_ff;
   logic [grc_pkg::DIST_BITS-1:0]        b_t_ff;
   logic                                 out_x, out_y, at_limit, terminate, hit_now;

   // result
   logic                                 res_hit_ff;
   logic [grc_pkg::CODE_BITS-1:0]        res_code_ff;
   logic [grc_pkg::DIST_BITS-1:0]        res_t_ff;
   logic                                 full_height_ff;
   logic [grc_pkg::DIVIDEND_BITS-1:0]    quotient;
   logic                                 div_done;
   logic [grc_pkg::SH_BITS-1:0]          height;
   logic                                 rsp_valid_ff;
   logic [8:0]                           rsp_column_ff;
   logic                                 rsp_hit_ff;
   logic [grc_pkg::CODE_BITS-1:0]        rsp_code_ff;
   logic [grc_pkg::DIST_BITS-1:0]        rsp_dist_ff;
   logic [grc_pkg::SH_BITS-1:0]          rsp_top_ff, rsp_height_ff;

   // settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         player_x_ff      <= 16'd14156;
         player_y_ff      <= 16'd9605;
         player_angle_ff  <= 16'd15885;
         fov_ff           <= 15'd10923;
         march_step_ff    <= 12'd41;
         max_distance_ff  <= 17'd81920;
         screen_height_ff <= 10'd512;
      end else if (csr_valid) begin
         case (csr_index)
            grc_pkg::CSR_PLAYER_X:      player_x_ff      <= csr_data[grc_pkg::POS_BITS-1:0];
            grc_pkg::CSR_PLAYER_Y:      player_y_ff      <= csr_data[grc_pkg::POS_BITS-1:0];
            grc_pkg::CSR_PLAYER_ANGLE:  player_angle_ff  <= csr_data[grc_pkg::ANGLE_BITS-1:0];
            grc_pkg::CSR_FIELD_OF_VIEW: fov_ff           <= csr_data[grc_pkg::FOV_BITS-1:0];
            grc_pkg::CSR_MARCH_STEP:    march_step_ff    <= csr_data[grc_pkg::STEP_BITS-1:0];
            grc_pkg::CSR_MAX_DISTANCE:  max_distance_ff  <= csr_data[grc_pkg::DIST_BITS-1:0];
            grc_pkg::CSR_SCREEN_HEIGHT: screen_height_ff <= csr_data[grc_pkg::SH_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // map store: RAM plus one valid bit per cell, unwritten cells read empty
   assign map_we    = (cmd.op == grc_pkg::OP_LOAD) &&
                      (32'(req_cell_index) < grc_pkg::MAP_CELLS);
   assign map_wdata = (req_cell_code > grc_pkg::CELL_EMPTY) ? grc_pkg::CELL_EMPTY
                                                           : req_cell_code;
   assign map_raddr = {acc_y_ff[grc_pkg::CELL_SHIFT +: grc_pkg::MAP_BITS],
                       acc_x_ff[grc_pkg::CELL_SHIFT +: grc_pkg::MAP_BITS]};

   grc_ram #(
      .WIDTH (grc_pkg::CODE_BITS),
      .DEPTH (grc_pkg::MAP_CELLS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (req_cell_index[grc_pkg::ADDR_BITS-1:0]),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_valid_ff <= '0;
      end else if (map_we) begin
         cell_valid_ff[req_cell_index[grc_pkg::ADDR_BITS-1:0]] <= 1'b1;
      end
      vld_q_ff <= cell_valid_ff[map_raddr];
   end

   assign code_eff = vld_q_ff ? map_q : grc_pkg::CELL_EMPTY;

   // ray angle and trig lookups
   assign offset_prod = fov_ff * req_column;
   assign ray_in      = player_angle_ff - grc_pkg::ANGLE_BITS'(fov_ff >> 1)
                      + grc_pkg::ANGLE_BITS'(offset_prod >> grc_pkg::COL_BITS);
   assign step_eff    = (march_step_ff == '0) ? grc_pkg::STEP_BITS'(1) : march_step_ff;

   always_comb begin
      case (cmd.op)
         grc_pkg::OP_LUT_C: lut_angle = ray_ff + grc_pkg::QUARTER_TURN;
         grc_pkg::OP_LUT_D: lut_angle = ray_ff - player_angle_ff + grc_pkg::QUARTER_TURN;
         default:           lut_angle = ray_ff;
      endcase
   end

   assign lut_val = grc_pkg::sine_lookup(lut_angle);

   always_comb begin
      case (cmd.op)
         grc_pkg::OP_MUL_X: begin
            mul_a = $signed(grc_pkg::MUL_A_BITS'(step_eff));
            mul_b = cos_ff;
         end
         grc_pkg::OP_MUL_Y: begin
            mul_a = $signed(grc_pkg::MUL_A_BITS'(step_eff));
            mul_b = sin_ff;
         end
         grc_pkg::OP_PERP: begin
            mul_a = $signed({1'b0, res_t_ff});
            mul_b = cd_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // march: stage A forms the cell address at t, stage B tests the cell read at the previous t
   assign out_x     = acc_x_ff[grc_pkg::ACC_BITS-1] ||
                      (|acc_x_ff[grc_pkg::ACC_BITS-2:grc_pkg::CELL_SHIFT+grc_pkg::MAP_BITS]);
   assign out_y     = acc_y_ff[grc_pkg::ACC_BITS-1] ||
                      (|acc_y_ff[grc_pkg::ACC_BITS-2:grc_pkg::CELL_SHIFT+grc_pkg::MAP_BITS]);
   assign at_limit  = (t_ff >= {1'b0, max_distance_ff});
   assign terminate = at_limit || out_x || out_y;
   assign hit_now   = b_valid_ff && (code_eff < grc_pkg::CELL_EMPTY);

   always_ff @(posedge clock) begin
      case (cmd.op)
         grc_pkg::OP_CAST: begin
            column_ff <= req_column;
            ray_ff    <= ray_in;
         end
         grc_pkg::OP_LUT_C: cos_ff <= lut_val;
         grc_pkg::OP_LUT_S: sin_ff <= lut_val;
         grc_pkg::OP_LUT_D: cd_ff  <= lut_val;
         grc_pkg::OP_MUL_X: dx_ff  <= mul_p;
         grc_pkg::OP_MUL_Y: begin
            dy_ff      <= mul_p;
            t_ff       <= '0;
            acc_x_ff   <= $signed({{(grc_pkg::ACC_BITS-grc_pkg::POS_BITS-grc_pkg::TRIG_FRAC){1'b0}},
                                   player_x_ff, {grc_pkg::TRIG_FRAC{1'b0}}});
            acc_y_ff   <= $signed({{(grc_pkg::ACC_BITS-grc_pkg::POS_BITS-grc_pkg::TRIG_FRAC){1'b0}},
                                   player_y_ff, {grc_pkg::TRIG_FRAC{1'b0}}});
            b_valid_ff <= 1'b0;
         end
         grc_pkg::OP_MARCH: begin
            if (hit_now) begin
               res_hit_ff  <= 1'b1;
               res_code_ff <= code_eff;
               res_t_ff    <= b_t_ff;
            end else if (terminate) begin
               res_hit_ff  <= 1'b0;
            end else begin
               t_ff       <= t_ff + grc_pkg::T_BITS'(step_eff);
               acc_x_ff   <= acc_x_ff + grc_pkg::ACC_BITS'(dx_ff);
               acc_y_ff   <= acc_y_ff + grc_pkg::ACC_BITS'(dy_ff);
               b_valid_ff <= 1'b1;
               b_t_ff     <= t_ff[grc_pkg::DIST_BITS-1:0];
            end
         end
         grc_pkg::OP_PERP: perp_ff <= mul_p;
         grc_pkg::OP_DIV_INIT: full_height_ff <= !status.perp_ok;
         default: begin
         end
      endcase
   end

   // height division
   grc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == grc_pkg::OP_DIV_INIT),
      .step_en  (cmd.op == grc_pkg::OP_DIV),
      .dividend ({screen_height_ff, {grc_pkg::POS_FRAC{1'b0}}}),
      .divisor  (perp_ff[grc_pkg::TRIG_FRAC +: grc_pkg::DIVISOR_BITS]),
      .quotient (quotient),
      .done     (div_done)
   );

   assign height = (full_height_ff ||
                    (quotient > grc_pkg::DIVIDEND_BITS'(screen_height_ff)))
                 ? screen_height_ff : quotient[grc_pkg::SH_BITS-1:0];

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == grc_pkg::OP_FINISH) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == grc_pkg::OP_FINISH) begin
         rsp_column_ff <= column_ff;
         rsp_hit_ff    <= res_hit_ff;
         if (res_hit_ff) begin
            rsp_code_ff   <= res_code_ff;
            rsp_dist_ff   <= res_t_ff;
            rsp_height_ff <= height;
            rsp_top_ff    <= (screen_height_ff >> 1) - (height >> 1);
         end else begin
            rsp_code_ff   <= '0;
            rsp_dist_ff   <= '0;
            rsp_height_ff <= '0;
            rsp_top_ff    <= '0;
         end
      end
   end

   assign status.col_ok     = (32'(req_column) < grc_pkg::SCREEN_COLUMNS);
   assign status.march_hit  = hit_now;
   assign status.march_miss = !hit_now && terminate;
   assign status.perp_ok    = !perp_ff[grc_pkg::PROD_BITS-1] &&
                              (|perp_ff[grc_pkg::PROD_BITS-2:grc_pkg::TRIG_FRAC]);
   assign status.div_done   = div_done;
   assign status.rsp_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_column_out    = rsp_column_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_wall_code     = rsp_code_ff;
   assign rsp_distance      = rsp_dist_ff;
   assign rsp_column_top    = rsp_top_ff;
   assign rsp_column_height = rsp_height_ff;

endmodule

@@ sv/grc_checker.sv @@
`timescale 1ns / 1ps
// Port checks for the grid column ray caster, bound to the top level
`include "grid_raycast_column_defines.svh"

module grc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_operation,
   input logic [7:0]                          req_cell_index,
   input logic [grc_pkg::CODE_BITS-1:0]       req_cell_code,
   input logic [8:0]                          req_column,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [8:0]                          rsp_column_out,
   input logic                                rsp_hit,
   input logic [grc_pkg::CODE_BITS-1:0]       rsp_wall_code,
   input logic [grc_pkg::DIST_BITS-1:0]       rsp_distance,
   input logic [grc_pkg::SH_BITS-1:0]         rsp_column_top,
   input logic [grc_pkg::SH_BITS-1:0]         rsp_column_height,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [grc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input logic [grc_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   `GRC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_distance) && $stable(rsp_column_out))
   `GRC_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp_hit, rsp_wall_code == '0 && rsp_distance == '0 && rsp_column_top == '0 && rsp_column_height == '0)
   `GRC_ASSERT_NOW(a_hit_code, rsp_valid && rsp_hit, rsp_wall_code < grc_pkg::CELL_EMPTY)
   `GRC_ASSERT_NEXT(a_cast_busy, req_valid && !req_stall && req_operation, req_stall)

endmodule

bind grid_raycast_column grc_checker u_grc_checker (.*);
